// ===== hdl/pht_pkg.sv =====
// Package for the per-owner handle table: field widths, operation and
// status codes, sequencer states and the control structs.
// No dependencies.
`default_nettype none

package pht_pkg;

    // Field widths of the item ports
    localparam int FUNC_W   = 2;
    localparam int OWNER_W  = 6;
    localparam int HID_W    = 8;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;

    // Default table geometry
    localparam int DEF_HANDLES = 128;
    localparam int DEF_OWNERS  = 64;

    // Free-handle scan width: bits of the live row checked per cycle
    localparam int SCAN_CHUNK = 8;
    localparam int SCAN_SEL_W = 3;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ALLOC = 2'd0,
        FUNC_GET   = 2'd1,
        FUNC_SET   = 2'd2,
        FUNC_FREE  = 2'd3
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_NOT_LIVE = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_EVAL,
        S_SCAN,
        S_ALLOC,
        S_DONE
    } state_t;

    // Datapath status seen by the sequencer
    typedef struct packed {
        logic in_valid;
        logic alloc_go;
        logic scan_hit;
        logic scan_last;
        logic clr_last;
        logic out_free;
    } pht_stat_t;

    // Step enables driven by the sequencer
    typedef struct packed {
        logic clr_en;
        logic in_ready;
        logic rd_en;
        logic eval_en;
        logic scan_en;
        logic alloc_en;
        logic done_en;
    } pht_ctl_t;

endpackage

`default_nettype wire

// ===== hdl/pht_ram.sv =====
// Single-port-write, single-port-read memory with registered read data.
// Used for the live bitmap rows and the data words. No dependencies.
`default_nettype none

module pht_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/pht_ctrl.sv =====
// Sequencer of the handle table: clear pass, read, evaluate, free-handle
// scan, allocate write and result hand-off. Depends on pht_pkg.
`default_nettype none

module pht_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire pht_pkg::pht_stat_t stat,
    output pht_pkg::pht_ctl_t       ctl
);

    import pht_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (stat.in_valid)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                state_next = stat.alloc_go ? S_SCAN : S_DONE;
            end
            S_SCAN:
            begin
                if (stat.scan_hit)
                begin
                    state_next = S_ALLOC;
                end
                else if (stat.scan_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_ALLOC:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // Step enables
    always_comb
    begin
        ctl = '0;
        case (state_reg)
            S_CLEAR: ctl.clr_en   = 1'b1;
            S_IDLE:  ctl.in_ready = 1'b1;
            S_READ:  ctl.rd_en    = 1'b1;
            S_EVAL:  ctl.eval_en  = 1'b1;
            S_SCAN:  ctl.scan_en  = 1'b1;
            S_ALLOC: ctl.alloc_en = 1'b1;
            S_DONE:  ctl.done_en  = 1'b1;
            default: ctl = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/per_owner_handle_table_core.sv =====
// Per-owner handle table: lowest-free handle allocation, one data word each.
// Steps: an item is taken in idle, then read and evaluated; allocate then scans
// the live row for a free handle (8 bitmap bits a step) and writes it, and is
// full when no step finds one. The result loads when the output is free. One item at a time: the
// next item is taken the cycle after the result loads.
// Reset: a clearing pass over every owner row zeroes the live bitmap first.
`default_nettype none

module per_owner_handle_table_core #(
    parameter int HANDLES_PER_OWNER = pht_pkg::DEF_HANDLES,
    parameter int OWNER_COUNT       = pht_pkg::DEF_OWNERS
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [pht_pkg::FUNC_W-1:0]    func,
    input  wire logic [pht_pkg::OWNER_W-1:0]   owner,
    input  wire logic [pht_pkg::HID_W-1:0]     handle_id,
    input  wire logic [pht_pkg::VALUE_W-1:0]   write_value,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic      [pht_pkg::STATUS_W-1:0]  status,
    output logic      [pht_pkg::HID_W-1:0]     alloc_handle,
    output logic      [pht_pkg::VALUE_W-1:0]   read_value
);

    import pht_pkg::*;

    localparam int ROW_W      = HANDLES_PER_OWNER;
    localparam int OA_W       = (OWNER_COUNT > 1) ? $clog2(OWNER_COUNT) : 1;
    localparam int SLOT_W     = (HANDLES_PER_OWNER > 1) ? $clog2(HANDLES_PER_OWNER) : 1;
    localparam int NCHUNK     = (HANDLES_PER_OWNER + SCAN_CHUNK - 1) / SCAN_CHUNK;
    localparam int CIDX_W     = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int PAD_W      = NCHUNK * SCAN_CHUNK;
    localparam int DATA_DEPTH = OWNER_COUNT * HANDLES_PER_OWNER;
    localparam int DA_W       = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1;

    pht_stat_t stat;
    pht_ctl_t  ctl;

    // Item registers
    func_t                func_reg;
    logic [OWNER_W-1:0]   owner_reg;
    logic [HID_W-1:0]     hid_reg;
    logic [VALUE_W-1:0]   wval_reg;
    logic [DA_W-1:0]      base_reg;
    logic [DA_W-1:0]      daddr_reg;
    logic [DA_W-1:0]      daddr_next;

    // Work registers
    logic [ROW_W-1:0]     row_reg;
    logic [ROW_W-1:0]     row_next;
    logic [CIDX_W-1:0]    scan_idx_reg;
    logic [CIDX_W-1:0]    scan_idx_next;
    logic [SLOT_W-1:0]    slot_reg;
    logic [SLOT_W-1:0]    slot_next;
    logic [OA_W-1:0]      clr_cnt_reg;
    logic [OA_W-1:0]      clr_cnt_next;

    // Result and output registers
    status_t              res_status_reg;
    status_t              res_status_next;
    logic [HID_W-1:0]     res_handle_reg;
    logic [HID_W-1:0]     res_handle_next;
    logic [VALUE_W-1:0]   res_value_reg;
    logic [VALUE_W-1:0]   res_value_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [STATUS_W-1:0]  out_status_reg;
    logic [HID_W-1:0]     out_handle_reg;
    logic [VALUE_W-1:0]   out_value_reg;

    // Memory ports
    logic                 map_wr_en;
    logic [OA_W-1:0]      map_wr_addr;
    logic [ROW_W-1:0]     map_wr_data;
    logic [ROW_W-1:0]     map_rd_data;
    logic                 data_wr_en;
    logic [DA_W-1:0]      data_wr_addr;
    logic [VALUE_W-1:0]   data_wr_data;
    logic [DA_W-1:0]      data_rd_addr;
    logic [VALUE_W-1:0]   data_rd_data;

    // Decode
    logic                 in_fire;
    logic                 out_free;
    logic                 owner_ok;
    logic                 hid_ok;
    logic [SLOT_W-1:0]    hid_slot;
    logic                 hit;
    logic [PAD_W-1:0]     row_pad;
    logic [SCAN_CHUNK-1:0] chunk;
    logic                 scan_hit;
    logic [SCAN_SEL_W-1:0] scan_sel;

    pht_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctl   (ctl)
    );

    pht_ram #(
        .WIDTH (ROW_W),
        .DEPTH (OWNER_COUNT)
    ) u_map_ram (
        .clk     (clk),
        .wr_en   (map_wr_en),
        .wr_addr (map_wr_addr),
        .wr_data (map_wr_data),
        .rd_en   (ctl.rd_en),
        .rd_addr (OA_W'(owner_reg)),
        .rd_data (map_rd_data)
    );

    pht_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DATA_DEPTH)
    ) u_data_ram (
        .clk     (clk),
        .wr_en   (data_wr_en),
        .wr_addr (data_wr_addr),
        .wr_data (data_wr_data),
        .rd_en   (ctl.rd_en),
        .rd_addr (data_rd_addr),
        .rd_data (data_rd_data)
    );

    assign in_fire  = in_valid && ctl.in_ready;
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = !ctl.in_ready;

    // Handle lookup against the row read back from the bitmap
    assign owner_ok = 32'(owner_reg) < OWNER_COUNT;
    assign hid_ok   = (hid_reg != '0) && (32'(hid_reg) <= HANDLES_PER_OWNER);
    assign hid_slot = SLOT_W'(hid_reg - HID_W'(1));
    assign hit      = owner_ok && hid_ok && map_rd_data[hid_slot];
    assign data_rd_addr = base_reg + DA_W'(hid_slot);

    // Free-handle scan: bits past the last handle read as live
    assign row_pad = ~(PAD_W'(~row_reg));
    assign chunk   = row_pad[scan_idx_reg*SCAN_CHUNK +: SCAN_CHUNK];

    always_comb
    begin
        scan_hit = 1'b0;
        scan_sel = '0;
        for (int i = SCAN_CHUNK - 1; i >= 0; i--)
        begin
            if (!chunk[i])
            begin
                scan_hit = 1'b1;
                scan_sel = SCAN_SEL_W'(i);
            end
        end
    end

    // Status to the sequencer
    always_comb
    begin
        stat.in_valid  = in_valid;
        stat.alloc_go  = (func_reg == FUNC_ALLOC) && owner_ok;
        stat.scan_hit  = scan_hit;
        stat.scan_last = scan_idx_reg == CIDX_W'(NCHUNK - 1);
        stat.clr_last  = clr_cnt_reg == OA_W'(OWNER_COUNT - 1);
        stat.out_free  = out_free;
    end

    // Step datapath
    always_comb
    begin
        row_next        = row_reg;
        scan_idx_next   = scan_idx_reg;
        slot_next       = slot_reg;
        clr_cnt_next    = clr_cnt_reg;
        daddr_next      = daddr_reg;
        res_status_next = res_status_reg;
        res_handle_next = res_handle_reg;
        res_value_next  = res_value_reg;
        map_wr_en       = 1'b0;
        map_wr_addr     = OA_W'(owner_reg);
        map_wr_data     = row_reg;
        data_wr_en      = 1'b0;
        data_wr_addr    = daddr_reg;
        data_wr_data    = wval_reg;

        if (ctl.clr_en)
        begin
            map_wr_en    = 1'b1;
            map_wr_addr  = clr_cnt_reg;
            map_wr_data  = '0;
            clr_cnt_next = clr_cnt_reg + OA_W'(1);
        end

        if (ctl.rd_en)
        begin
            daddr_next = data_rd_addr;
        end

        if (ctl.eval_en)
        begin
            row_next        = map_rd_data;
            scan_idx_next   = '0;
            res_status_next = ST_OK;
            res_handle_next = '0;
            res_value_next  = '0;
            if (func_reg == FUNC_ALLOC)
            begin
                res_status_next = ST_FULL;
            end
            else if (!hit)
            begin
                res_status_next = ST_NOT_LIVE;
            end
            else
            begin
                case (func_reg)
                    FUNC_GET:
                    begin
                        res_value_next = data_rd_data;
                    end
                    FUNC_SET:
                    begin
                        data_wr_en = 1'b1;
                    end
                    FUNC_FREE:
                    begin
                        map_wr_en   = 1'b1;
                        map_wr_data = map_rd_data & ~(ROW_W'(1) << hid_slot);
                    end
                    default:
                    begin
                        res_value_next = '0;
                    end
                endcase
            end
        end

        if (ctl.scan_en)
        begin
            slot_next = SLOT_W'({scan_idx_reg, scan_sel});
            if (!scan_hit)
            begin
                scan_idx_next = scan_idx_reg + CIDX_W'(1);
            end
        end

        // Claim the found handle and clear its data word
        if (ctl.alloc_en)
        begin
            map_wr_en       = 1'b1;
            map_wr_data     = row_reg | (ROW_W'(1) << slot_reg);
            data_wr_en      = 1'b1;
            data_wr_addr    = base_reg + DA_W'(slot_reg);
            data_wr_data    = '0;
            res_status_next = ST_OK;
            res_handle_next = HID_W'({1'b0, slot_reg} + (SLOT_W + 1)'(1));
        end
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (ctl.done_en && out_free)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            clr_cnt_reg   <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            clr_cnt_reg   <= clr_cnt_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            func_reg  <= func_t'(func);
            owner_reg <= owner;
            hid_reg   <= handle_id;
            wval_reg  <= write_value;
            base_reg  <= DA_W'(32'(owner) * HANDLES_PER_OWNER);
        end
        daddr_reg      <= daddr_next;
        row_reg        <= row_next;
        scan_idx_reg   <= scan_idx_next;
        slot_reg       <= slot_next;
        res_status_reg <= res_status_next;
        res_handle_reg <= res_handle_next;
        res_value_reg  <= res_value_next;
        if (ctl.done_en && out_free)
        begin
            out_status_reg <= res_status_reg;
            out_handle_reg <= res_handle_reg;
            out_value_reg  <= res_value_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign alloc_handle = out_handle_reg;
    assign read_value   = out_value_reg;

endmodule

`default_nettype wire

// ===== test/handle_table_checker.sv =====
// Checker for the per-owner handle table: watches both item channels,
// predicts each reply from its own copy of the live bitmap and data words,
// and compares replies in order. Depends on pht_pkg for widths and codes.

module handle_table_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire logic                          in_stall,
    input  wire logic [pht_pkg::FUNC_W-1:0]    func,
    input  wire logic [pht_pkg::OWNER_W-1:0]   owner,
    input  wire logic [pht_pkg::HID_W-1:0]     handle_id,
    input  wire logic [pht_pkg::VALUE_W-1:0]   write_value,
    input  wire logic                          out_valid,
    input  wire logic                          out_stall,
    input  wire logic [pht_pkg::STATUS_W-1:0]  status,
    input  wire logic [pht_pkg::HID_W-1:0]     alloc_handle,
    input  wire logic [pht_pkg::VALUE_W-1:0]   read_value,
    output int                                 mismatches,
    output int                                 outstanding
);
    import pht_pkg::*;

    localparam int HANDLES   = DEF_HANDLES;
    localparam int OWNERS    = DEF_OWNERS;
    localparam int SHOW_MAX  = 10;

    typedef struct packed {
        status_t             st;
        logic [HID_W-1:0]    nh;
        logic [VALUE_W-1:0]  rv;
    } reply_t;

    // Replies owed by the block, oldest first
    reply_t replies_due[$];

    // Shadow table: one live bit and one data word per handle per owner
    logic [HANDLES-1:0] live_rows [OWNERS];
    logic [VALUE_W-1:0] words [OWNERS][HANDLES];

    int fail_total;
    int shown;

    // Apply one request to the shadow table and build the reply it gives
    task automatic predict_reply(
        input  logic [FUNC_W-1:0]   f,
        input  logic [OWNER_W-1:0]  o,
        input  logic [HID_W-1:0]    h,
        input  logic [VALUE_W-1:0]  v,
        output reply_t              r
    );
        int  slot;
        int  own;
        int  hidx;
        bit  found;
        bit  live;
        own    = int'(o);
        hidx   = int'(h) - 1;
        r.st   = ST_OK;
        r.nh   = '0;
        r.rv   = '0;
        found  = 1'b0;
        if (func_t'(f) == FUNC_ALLOC) begin
            // lowest handle not live; full when none is left
            r.st = ST_FULL;
            if (own < OWNERS) begin
                for (slot = 0; slot < HANDLES && !found; slot++) begin
                    if (!live_rows[own][slot]) begin
                        live_rows[own][slot] = 1'b1;
                        words[own][slot]     = '0;
                        r.nh                 = HID_W'(slot + 1);
                        r.st                 = ST_OK;
                        found                = 1'b1;
                    end
                end
            end
        end
        else begin
            // handle 0 and handles past the table are never live
            live = (own < OWNERS) && (hidx >= 0) && (hidx < HANDLES);
            if (live) begin
                live = live_rows[own][hidx];
            end
            if (!live) begin
                r.st = ST_NOT_LIVE;
            end
            else begin
                case (func_t'(f))
                    FUNC_GET:  r.rv = words[own][hidx];
                    FUNC_SET:  words[own][hidx] = v;
                    default:   live_rows[own][hidx] = 1'b0;
                endcase
            end
        end
    endtask

    // Channel monitor: compare accepted replies, then predict accepted items
    always @(posedge clk or negedge rst_n) begin : monitor
        reply_t want;
        reply_t got;
        if (!rst_n) begin
            replies_due.delete();
            for (int i = 0; i < OWNERS; i++) begin
                live_rows[i] = '0;
            end
            fail_total = 0;
            shown      = 0;
        end
        else begin
            if (out_valid && !out_stall) begin
                got.st = status_t'(status);
                got.nh = alloc_handle;
                got.rv = read_value;
                if (replies_due.size() == 0) begin
                    fail_total++;
                    if (shown < SHOW_MAX) begin
                        shown++;
                        $display("checker: reply with none due: status=%0d handle=%0d data=%h",
                                 status, alloc_handle, read_value);
                    end
                end
                else begin
                    want = replies_due.pop_front();
                    if (got !== want) begin
                        fail_total++;
                        if (shown < SHOW_MAX) begin
                            shown++;
                            $display({"checker: reply mismatch: status exp %0d got %0d, ",
                                      "handle exp %0d got %0d, data exp %h got %h"},
                                     want.st, status, want.nh, alloc_handle,
                                     want.rv, read_value);
                        end
                    end
                end
            end
            if (in_valid && !in_stall) begin
                predict_reply(func, owner, handle_id, write_value, want);
                replies_due.push_back(want);
            end
        end
        mismatches  <= fail_total;
        outstanding <= replies_due.size();
    end

endmodule

// ===== test/tb_top.sv =====
// Top of the handle table testbench: clock, reset, request stimulus and
// reply back-pressure, watchdog and verdict. Depends on pht_pkg, the
// per_owner_handle_table_core block and handle_table_checker.

module tb_top;
    import pht_pkg::*;

    localparam int HOLD_CYCLES  = 400;
    localparam int IDLE_LIMIT   = 5000;
    localparam int RANDOM_ITEMS = 2000;
    localparam int DRAIN_CYCLES = 30;
    localparam int HOLD_AT_ITEM = 600;

    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 in_valid    = 1'b0;
    logic [FUNC_W-1:0]    func        = FUNC_ALLOC;
    logic [OWNER_W-1:0]   owner       = '0;
    logic [HID_W-1:0]     handle_id   = '0;
    logic [VALUE_W-1:0]   write_value = '0;
    logic                 out_stall   = 1'b0;

    wire                  in_stall;
    wire                  out_valid;
    wire [STATUS_W-1:0]   status;
    wire [HID_W-1:0]      alloc_handle;
    wire [VALUE_W-1:0]    read_value;

    int mismatches;
    int outstanding;

    // Upper bound on the handles each owner has been given, steers handle picks
    int alloc_hint [DEF_OWNERS];
    int items_sent;
    int idle_cycles;
    bit hold_req;
    bit hold_done;
    bit no_idle;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    per_owner_handle_table_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (func),
        .owner        (owner),
        .handle_id    (handle_id),
        .write_value  (write_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .alloc_handle (alloc_handle),
        .read_value   (read_value)
    );

    handle_table_checker u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (func),
        .owner        (owner),
        .handle_id    (handle_id),
        .write_value  (write_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .alloc_handle (alloc_handle),
        .read_value   (read_value),
        .mismatches   (mismatches),
        .outstanding  (outstanding)
    );

    // Mostly no gap, some short gaps, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Offer one request item and hold it until the block takes it
    task automatic send_item(
        input func_t               f,
        input logic [OWNER_W-1:0]  o,
        input logic [HID_W-1:0]    h,
        input logic [VALUE_W-1:0]  v
    );
        int gap;
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        func        <= f;
        owner       <= o;
        handle_id   <= h;
        write_value <= v;
        in_valid    <= 1'b1;
        do @(posedge clk); while (in_stall);
        items_sent++;
        if (f == FUNC_ALLOC && alloc_hint[o] < DEF_HANDLES) begin
            alloc_hint[o]++;
        end
        if (items_sent == HOLD_AT_ITEM) begin
            hold_req = 1'b1;
        end
    endtask

    // Run one owner into table full, free a few, refill past full, then read a few
    task automatic fill_owner(input logic [OWNER_W-1:0] o);
        repeat (DEF_HANDLES + 2) begin
            send_item(FUNC_ALLOC, o, HID_W'($urandom), $urandom);
        end
        repeat (5) begin
            send_item(FUNC_FREE, o, HID_W'($urandom_range(1, DEF_HANDLES)), $urandom);
        end
        repeat (6) begin
            send_item(FUNC_ALLOC, o, '0, '0);
        end
        repeat (4) begin
            send_item(FUNC_GET, o, HID_W'($urandom_range(1, DEF_HANDLES)), '0);
        end
    endtask

    // Reply back-pressure, with one long hold-off while requests keep coming
    initial begin : reply_stall
        int n;
        @(posedge clk);
        forever begin
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                out_stall <= 1'b1;
                n = HOLD_CYCLES;
            end
            else begin
                n = no_idle ? 0 : pick_gap();
                if (n == 0) begin
                    out_stall <= 1'b0;
                    n = $urandom_range(1, 6);
                end
                else begin
                    out_stall <= 1'b1;
                end
            end
            repeat (n) @(posedge clk);
        end
    end

    // Watchdog on cycles with no item moving on either channel
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb_top: done, errors");
                $finish;
            end
            else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Stimulus and verdict
    initial begin : stimulus
        logic [OWNER_W-1:0]  pool [3];
        logic [OWNER_W-1:0]  o;
        logic [HID_W-1:0]    h;
        logic [VALUE_W-1:0]  v;
        func_t               f;
        int                  sel;
        int                  span;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: data clear on allocate, set/get, reuse of lowest handle,
        // handles not live, handle 0, handles past the table, both owner ends
        send_item(FUNC_ALLOC, 6'd0,  8'd255, 32'hFFFF_FFFF);
        send_item(FUNC_GET,   6'd0,  8'd1,   32'h0);
        send_item(FUNC_SET,   6'd0,  8'd1,   32'hFFFF_FFFF);
        send_item(FUNC_GET,   6'd0,  8'd1,   32'h0);
        send_item(FUNC_ALLOC, 6'd0,  8'd0,   32'h0);
        send_item(FUNC_SET,   6'd0,  8'd2,   32'h0);
        send_item(FUNC_GET,   6'd0,  8'd2,   32'hFFFF_FFFF);
        send_item(FUNC_FREE,  6'd0,  8'd1,   32'h0);
        send_item(FUNC_FREE,  6'd0,  8'd1,   32'h0);
        send_item(FUNC_SET,   6'd0,  8'd1,   32'h1234_5678);
        send_item(FUNC_GET,   6'd0,  8'd1,   32'h0);
        send_item(FUNC_ALLOC, 6'd0,  8'd0,   32'h0);
        send_item(FUNC_GET,   6'd0,  8'd1,   32'h0);
        send_item(FUNC_GET,   6'd0,  8'd0,   32'h0);
        send_item(FUNC_SET,   6'd0,  8'd0,   32'hFFFF_FFFF);
        send_item(FUNC_FREE,  6'd0,  8'd0,   32'h0);
        send_item(FUNC_GET,   6'd0,  8'd255, 32'h0);
        send_item(FUNC_SET,   6'd63, 8'd129, 32'hA5A5_A5A5);
        send_item(FUNC_FREE,  6'd63, 8'd128, 32'h0);
        send_item(FUNC_ALLOC, 6'd63, 8'd0,   32'h0);
        send_item(FUNC_SET,   6'd63, 8'd1,   32'h5A5A_5A5A);
        send_item(FUNC_GET,   6'd63, 8'd1,   32'h0);
        send_item(FUNC_GET,   6'd63, 8'd2,   32'h0);

        // Table full on the top owner
        fill_owner(6'd63);

        // Random mix, concentrated on a few owners at a time
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 100 == 0) begin
                for (int k = 0; k < 3; k++) begin
                    pool[k] = OWNER_W'($urandom_range(0, DEF_OWNERS - 1));
                end
            end
            if (i == RANDOM_ITEMS / 2) begin
                fill_owner(pool[0]);
            end
            no_idle = (i >= 1200 && i < 1400);

            sel = $urandom_range(0, 99);
            if (sel < 30) begin
                f = FUNC_ALLOC;
            end
            else if (sel < 55) begin
                f = FUNC_GET;
            end
            else if (sel < 80) begin
                f = FUNC_SET;
            end
            else begin
                f = FUNC_FREE;
            end

            if ($urandom_range(0, 99) < 85) begin
                o = pool[$urandom_range(0, 2)];
            end
            else begin
                o = OWNER_W'($urandom_range(0, DEF_OWNERS - 1));
            end

            // mostly handles that may be live, some anywhere in the field
            span = alloc_hint[o] + 2;
            if (span > DEF_HANDLES) begin
                span = DEF_HANDLES;
            end
            if ($urandom_range(0, 99) < 85) begin
                h = HID_W'($urandom_range(1, span));
            end
            else begin
                h = HID_W'($urandom_range(0, 255));
            end

            sel = $urandom_range(0, 9);
            if (sel == 0) begin
                v = '0;
            end
            else if (sel == 1) begin
                v = '1;
            end
            else begin
                v = $urandom;
            end

            send_item(f, o, h, v);
        end
        in_valid <= 1'b0;
        no_idle = 1'b0;

        // Drain: wait for owed replies, then let the block settle
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && outstanding == 0) begin
            $display("tb_top: done, clean");
        end
        else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
